@@ hw/rtl/ils_pkg.sv @@
// shared types and constants of the indexed list store
`default_nettype none

package ils_pkg;

  // fixed field widths of the request and response transactions
  localparam int unsigned OpW     = 3;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned DataW   = 32;
  localparam int unsigned LengthW = 5;

  // request operation codes
  typedef enum logic [OpW-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_SET     = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_GET     = 3'd4,
    OP_REVERSE = 3'd5,
    OP_CLEAR   = 3'd6
  } op_e;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // load request fields
    logic exec;     // perform operation, load response
  } ils_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/ils_ctrl.sv @@
// controller state machine: handshakes and sequencing of one transaction
`default_nettype none

module ils_ctrl
  import ils_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output ils_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // state and response valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // take a request once the response slot is free or being emptied
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // response slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // response slot is always empty while an operation executes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> !out_valid_q)
    else $error("response slot occupied during execute");

  // a response appears only after an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("response without execute");

  // every accepted request is executed in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_EXEC)
    else $error("accepted request not executed");

endmodule

`default_nettype wire

@@ hw/rtl/ils_datapath.sv @@
// datapath: request registers, row of element cells, count and response registers
`default_nettype none

module ils_datapath
  import ils_pkg::*;
#(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ils_cmd_t           cmd_i,
  input  wire logic [OpW-1:0]     op_i,
  input  wire logic [IndexW-1:0]  index_i,
  input  wire logic [ValueW-1:0]  value_i,
  output logic                    ok_o,
  output logic [DataW-1:0]        data_o,
  output logic [LengthW-1:0]      length_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // common width for positions, indexes and the count
  localparam int unsigned LW0 = (CW > IndexW) ? CW : IndexW;
  localparam int unsigned LW  = (LW0 > LengthW) ? LW0 : LengthW;
  // width that holds both an element and a value or data word
  localparam int unsigned XW  = (ELEMENT_WIDTH > ValueW) ? ELEMENT_WIDTH : ValueW;

  logic [OpW-1:0]           op_q;
  logic [IndexW-1:0]        index_q;
  logic [ValueW-1:0]        value_q;
  logic [ELEMENT_WIDTH-1:0] cells_q [DEPTH];
  logic [ELEMENT_WIDTH-1:0] cells_d [DEPTH];
  logic [CW-1:0]            count_q, count_d;
  logic                     rev_q, rev_d;
  logic                     ok_q, ok_d;
  logic [DataW-1:0]         data_q, data_d;

  logic [LW-1:0]            cnt_ext, idx_ext, pos_log, ins_pos, acc_pos, pos;
  logic                     can_grow, in_range;
  logic                     do_ins, do_rem, do_set, do_rd;
  logic [XW-1:0]            val_ext, rd_ext;
  logic [ELEMENT_WIDTH-1:0] elem, rd_elem;

  // request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      index_q <= index_i;
      value_q <= value_i;
    end
  end

  // bounds and physical positions; reversal flips the cell order
  assign cnt_ext  = LW'(count_q);
  assign idx_ext  = LW'(index_q);
  assign pos_log  = (op_q == OP_APPEND) ? cnt_ext : idx_ext;
  assign can_grow = cnt_ext < LW'(DEPTH);
  assign in_range = idx_ext < cnt_ext;
  assign ins_pos  = rev_q ? (cnt_ext - pos_log) : pos_log;
  assign acc_pos  = rev_q ? (cnt_ext - LW'(1) - idx_ext) : idx_ext;

  // element value and read word
  assign val_ext = XW'(value_q);
  assign elem    = val_ext[ELEMENT_WIDTH-1:0];
  assign rd_elem = cells_q[pos[AW-1:0]];
  assign rd_ext  = XW'(rd_elem);

  // operation decode
  always_comb begin
    ok_d    = 1'b0;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_set  = 1'b0;
    do_rd   = 1'b0;
    pos     = acc_pos;
    count_d = count_q;
    rev_d   = rev_q;
    case (op_q)
      OP_APPEND, OP_INSERT: begin
        pos    = ins_pos;
        ok_d   = (pos_log <= cnt_ext) && can_grow;
        do_ins = ok_d;
      end
      OP_SET: begin
        ok_d   = in_range;
        do_set = ok_d;
        do_rd  = ok_d;
      end
      OP_REMOVE: begin
        ok_d   = in_range;
        do_rem = ok_d;
        do_rd  = ok_d;
      end
      OP_GET: begin
        ok_d  = in_range;
        do_rd = ok_d;
      end
      OP_REVERSE: begin
        ok_d  = 1'b1;
        rev_d = !rev_q;
      end
      OP_CLEAR: begin
        ok_d    = 1'b1;
        count_d = '0;
        rev_d   = 1'b0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_rem) begin
      count_d = count_q - CW'(1);
    end
    data_d = do_rd ? rd_ext[DataW-1:0] : '0;
  end

  // row of cells: each cell takes its lower or upper neighbour or the new value
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    localparam logic [LW-1:0] JPos = LW'(j);
    logic [ELEMENT_WIDTH-1:0] from_below, from_above;
    if (j > 0) begin : g_below
      assign from_below = cells_q[j-1];
    end else begin : g_no_below
      assign from_below = cells_q[j];
    end
    if (j < DEPTH - 1) begin : g_above
      assign from_above = cells_q[j+1];
    end else begin : g_no_above
      assign from_above = cells_q[j];
    end
    always_comb begin
      cells_d[j] = cells_q[j];
      if (do_ins) begin
        if (JPos == pos) begin
          cells_d[j] = elem;
        end else if (JPos > pos) begin
          cells_d[j] = from_below;
        end
      end else if (do_rem) begin
        if (JPos >= pos) begin
          cells_d[j] = from_above;
        end
      end else if (do_set) begin
        if (JPos == pos) begin
          cells_d[j] = elem;
        end
      end
    end
  end

  // element storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cells_q <= cells_d;
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q   <= ok_d;
      data_q <= data_d;
    end
  end

  // list length and orientation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rev_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  assign ok_o     = ok_q;
  assign data_o   = data_q;
  assign length_o = cnt_ext[LengthW-1:0];

  // the list never holds more than its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(count_q) <= LW'(DEPTH))
    else $error("count above capacity");

  // a successful insert grows the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && do_ins |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the list");

  // count only changes in an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q) && $stable(rev_q))
    else $error("list state changed outside execute");

endmodule

`default_nettype wire

@@ hw/rtl/indexed_list_store_unit.sv @@
// top level of the indexed list store: controller and datapath
//
//  channel   direction  handshake                  payload
//  request   in         in_valid_i / in_ready_o    op_i, index_i, value_i
//  response  out        out_valid_o / out_ready_i  ok_o, data_o, length_o
//
// each transaction is first captured into the request registers, then the execute
// step runs the operation across the row of cells, which moves every entry at once
// reverse flips an orientation flag, so no operation needs more than one pass
// the response register holds the result; a new request is taken once the
// response has gone or goes at the same edge
// reset clears the count and orientation; cells hold unknown data until written
`default_nettype none

module indexed_list_store_unit
  import ils_pkg::*;
#(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [OpW-1:0]     op_i,
  input  wire logic [IndexW-1:0]  index_i,
  input  wire logic [ValueW-1:0]  value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    ok_o,
  output logic [DataW-1:0]        data_o,
  output logic [LengthW-1:0]      length_o
);

  ils_cmd_t cmd;

  // sequencing and handshakes
  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // storage and operations
  ils_datapath #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .op_i     (op_i),
    .index_i  (index_i),
    .value_i  (value_i),
    .ok_o     (ok_o),
    .data_o   (data_o),
    .length_o (length_o)
  );

endmodule

`default_nettype wire
